// ===== src/ccdt_pkg.sv =====
// ============================================================================
// ccdt_pkg - shared types and constants of the CCD tape line tracker
// Register codes, reset values, Q0.16 smoothing weights, frame summary type.
// ============================================================================
package ccdt_pkg;

  localparam int unsigned PIXELS     = 128;
  localparam int unsigned SCAN_FIRST = 2;

  // Q0.16 weights: found 0.65/0.35, decay 0.98/0.02
  localparam logic [15:0] Q_FOUND_OLD = 16'd42598;
  localparam logic [15:0] Q_FOUND_NEW = 16'd22938;
  localparam logic [15:0] Q_DECAY_OLD = 16'd64225;
  localparam logic [15:0] Q_DECAY_REF = 16'd1311;

  localparam logic [7:0]  LOST_MAX    = 8'd255;
  localparam logic [6:0]  PCNT_MAX    = 7'd127;

  localparam logic [11:0] RST_DARK_THRESHOLD   = 12'd2048;
  localparam logic [7:0]  RST_WIDTH_MIN        = 8'd3;
  localparam logic [7:0]  RST_WIDTH_MAX        = 8'd30;
  localparam logic [6:0]  RST_CENTER_REFERENCE = 7'd64;
  localparam logic [7:0]  RST_HOLD_FRAMES      = 8'd3;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 12;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DARK_THRESHOLD   = 3'd0,
    REG_WIDTH_MIN        = 3'd1,
    REG_WIDTH_MAX        = 3'd2,
    REG_CENTER_REFERENCE = 3'd3,
    REG_HOLD_FRAMES      = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [11:0] dark_threshold;
    logic [7:0]  width_min;
    logic [7:0]  width_max;
    logic [6:0]  center_reference;
    logic [7:0]  hold_frames;
  } ccdt_cfg_t;

  // what the front hands the back at each frame end
  typedef struct packed {
    logic       latched;
    logic [6:0] left_edge;
    logic [6:0] right_edge;
  } frame_sum_t;

endpackage

// ===== src/ccdt_if.sv =====
// ============================================================================
// ccdt_if - channel interfaces of the CCD tape line tracker
// Pixel input channel and frame result channel, valid/ready handshake.
// ============================================================================
interface ccdt_pix_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_value;
  logic        frame_end;

  modport source (output valid, pixel_value, frame_end, input ready);
  modport sink   (input valid, pixel_value, frame_end, output ready);
endinterface

interface ccdt_res_if;
  logic              valid;
  logic              ready;
  logic              track_valid;
  logic [6:0]        track_center;
  logic [7:0]        strip_width;
  logic [6:0]        left_edge;
  logic [6:0]        right_edge;
  logic signed [7:0] position_error;
  logic [7:0]        lost_count;

  modport source (output valid, track_valid, track_center, strip_width, left_edge,
                  right_edge, position_error, lost_count, input ready);
  modport sink   (input valid, track_valid, track_center, strip_width, left_edge,
                  right_edge, position_error, lost_count, output ready);
endinterface

// ===== src/ccdt_front.sv =====
// ============================================================================
// ccdt_front - pixel scanner
// Thresholds each pixel, finds dark-run edges and latches the first run of
// accepted width; pushes a frame summary at frame end.
// ============================================================================
module ccdt_front
  import ccdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ccdt_cfg_t   cfg,
  ccdt_pix_if.sink    pix,
  input  logic        q_full,
  output logic        push,
  output frame_sum_t  push_data
);

  localparam logic [6:0] SCAN_LO = 7'(SCAN_FIRST + 1);
  localparam logic [6:0] SCAN_HI = 7'(PIXELS - 2);

  logic [6:0] pixel_counter;
  logic [1:0] dark_history;
  logic       left_seen;
  logic [6:0] left_candidate;
  logic       tape_latched;
  logic [6:0] latched_left;
  logic [6:0] latched_right;

  logic       left_seen_next;
  logic [6:0] left_candidate_next;
  logic       tape_latched_next;
  logic [6:0] latched_left_next;
  logic [6:0] latched_right_next;

  logic       dark;
  logic       scan_en;
  logic [6:0] pos;
  logic [7:0] run_width;
  logic       accept;

  assign pix.ready = !q_full;
  assign accept    = pix.valid && pix.ready;
  assign dark      = pix.pixel_value < cfg.dark_threshold;
  assign scan_en   = !tape_latched && pixel_counter >= SCAN_LO && pixel_counter <= SCAN_HI;
  assign pos       = pixel_counter - 7'd1;

  // position pos is tested once its right neighbor (this pixel) is here
  always_comb begin
    left_seen_next      = left_seen;
    left_candidate_next = left_candidate;
    tape_latched_next   = tape_latched;
    latched_left_next   = latched_left;
    latched_right_next  = latched_right;
    run_width           = '0;
    if (scan_en) begin
      if (!left_seen && dark_history[0] && !dark_history[1]) begin
        left_seen_next      = 1'b1;
        left_candidate_next = pos;
      end
      if (left_seen_next && dark_history[0] && !dark) begin
        run_width = {1'b0, pos} - {1'b0, left_candidate_next} + 8'd1;
        if (run_width >= cfg.width_min && run_width <= cfg.width_max) begin
          tape_latched_next  = 1'b1;
          latched_left_next  = left_candidate_next;
          latched_right_next = pos;
        end
        left_seen_next = 1'b0;
      end
    end
  end

  assign push                 = accept && pix.frame_end;
  assign push_data.latched    = tape_latched_next;
  assign push_data.left_edge  = latched_left_next;
  assign push_data.right_edge = latched_right_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_counter  <= '0;
      dark_history   <= '0;
      left_seen      <= 1'b0;
      left_candidate <= '0;
      tape_latched   <= 1'b0;
      latched_left   <= '0;
      latched_right  <= '0;
    end else if (accept) begin
      if (pix.frame_end) begin
        pixel_counter  <= '0;
        dark_history   <= '0;
        left_seen      <= 1'b0;
        left_candidate <= '0;
        tape_latched   <= 1'b0;
        latched_left   <= '0;
        latched_right  <= '0;
      end else begin
        if (pixel_counter != PCNT_MAX) pixel_counter <= pixel_counter + 7'd1;
        dark_history   <= {dark_history[0], dark};
        left_seen      <= left_seen_next;
        left_candidate <= left_candidate_next;
        tape_latched   <= tape_latched_next;
        latched_left   <= latched_left_next;
        latched_right  <= latched_right_next;
      end
    end
  end

endmodule

// ===== src/ccdt_queue.sv =====
// ============================================================================
// ccdt_queue - two-entry frame summary queue
// Decouples the pixel scanner from the frame result unit.
// ============================================================================
module ccdt_queue
  import ccdt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_sum_t push_data,
  output logic       full,
  input  logic       pop,
  output frame_sum_t head,
  output logic       empty
);

  frame_sum_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue pop while empty");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 2'd1)
    else $error("queue count lost a push");

endmodule

// ===== src/ccdt_back.sv =====
// ============================================================================
// ccdt_back - frame result unit
// Lost-frame hold, Q7.16 smoothing and decay, registered result output.
// ============================================================================
module ccdt_back
  import ccdt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  ccdt_cfg_t  cfg,
  input  frame_sum_t head,
  input  logic       empty,
  output logic       pop,
  ccdt_res_if.source res
);

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_FIN} state_t;
  typedef enum logic [1:0] {K_FOUND, K_HELD, K_DECAY} kind_t;

  state_t      state;
  kind_t       kind;
  frame_sum_t  work;
  logic [7:0]  lost_frames;
  logic [7:0]  lost_work;
  logic [22:0] smoothed_center;
  logic [6:0]  held_center;
  logic [6:0]  found_center;
  logic [38:0] prod_old;
  logic [21:0] prod_new;

  logic [7:0]  lost_next;
  logic [7:0]  edge_sum;
  logic [22:0] smoothed_next;
  logic [6:0]  center_next;
  logic        out_free;

  assign pop      = (state == S_IDLE) && !empty;
  assign out_free = !res.valid || res.ready;
  assign edge_sum = {1'b0, work.left_edge} + {1'b0, work.right_edge};

  always_comb begin
    if (work.latched)               lost_next = '0;
    else if (lost_frames == LOST_MAX) lost_next = LOST_MAX;
    else                            lost_next = lost_frames + 8'd1;
  end

  // product low 16 bits only come from the old-value term
  assign smoothed_next = prod_old[38:16] + {1'b0, prod_new};

  always_comb begin
    case (kind)
      K_FOUND: center_next = found_center;
      K_HELD:  center_next = held_center;
      default: center_next = smoothed_next[22:16];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      kind            <= K_FOUND;
      work            <= '0;
      lost_frames     <= '0;
      lost_work       <= '0;
      smoothed_center <= {RST_CENTER_REFERENCE, 16'd0};
      held_center     <= RST_CENTER_REFERENCE;
      found_center    <= '0;
      prod_old        <= '0;
      prod_new        <= '0;
      res.valid          <= 1'b0;
      res.track_valid    <= 1'b0;
      res.track_center   <= '0;
      res.strip_width    <= '0;
      res.left_edge      <= '0;
      res.right_edge     <= '0;
      res.position_error <= '0;
      res.lost_count     <= '0;
    end else begin
      // in S_FIN the finish step owns valid
      if (res.valid && res.ready && state != S_FIN) res.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!empty) begin
            work  <= head;
            state <= S_CALC;
          end
        end
        S_CALC: begin
          lost_work    <= lost_next;
          found_center <= edge_sum[7:1];
          if (work.latched) begin
            kind     <= K_FOUND;
            prod_old <= 39'(Q_FOUND_OLD) * 39'(smoothed_center);
            prod_new <= 22'(Q_FOUND_NEW) * 22'(edge_sum[7:1]);
          end else begin
            kind     <= (lost_next <= cfg.hold_frames) ? K_HELD : K_DECAY;
            prod_old <= 39'(Q_DECAY_OLD) * 39'(smoothed_center);
            prod_new <= 22'(Q_DECAY_REF) * 22'(cfg.center_reference);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            lost_frames <= lost_work;
            held_center <= center_next;
            if (kind != K_HELD) smoothed_center <= smoothed_next;
            res.valid          <= 1'b1;
            res.track_valid    <= kind != K_DECAY;
            res.track_center   <= center_next;
            res.strip_width    <= work.latched ?
                                  {1'b0, work.right_edge} - {1'b0, work.left_edge} + 8'd1
                                  : 8'd0;
            res.left_edge      <= work.left_edge;
            res.right_edge     <= work.right_edge;
            res.position_error <= {1'b0, center_next} - {1'b0, cfg.center_reference};
            res.lost_count     <= lost_work;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_found_clears_lost: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.strip_width != 8'd0) |-> (res.lost_count == 8'd0 && res.track_valid))
    else $error("found frame reports lost frames or invalid line");
  a_fin_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && res.valid && !res.ready) |=> state == S_FIN)
    else $error("result unit overwrote a pending result");
  a_stall_holds_lost: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !out_free) |=> lost_frames == $past(lost_frames))
    else $error("lost count moved while result stalled");

endmodule

// ===== src/ccd_tape_line_tracker.sv =====
// ============================================================================
// ccd_tape_line_tracker - linear CCD dark tape line tracker
// Per-pixel dark-run detection with a per-frame center, hold and decay result.
// ============================================================================
// Usage:
//   pix  : one pixel per transfer, in index order; frame_end marks the last
//          pixel of a frame. One pixel per cycle is taken while the summary
//          queue has room.
//   res  : exactly one result transfer per frame, none for other pixels.
//   cfg  : cfg_we/cfg_index/cfg_data write one register per cycle; write only
//          while the block is idle.
// A frame summary passes through the queue, then the result unit's
//   idle/multiply/finish sequence, which waits in finish while res stalls;
//   frames shorter than that sequence slow the pixel input once the
//   two-entry queue is full.
// Reset: rst (synchronous) restores register defaults, clears the scanner and
//   queue, and sets the smoothed and held centers to pixel 64.
// Stall: while res is not ready the pending result holds; the scanner keeps
//   taking pixels until two further frame summaries fill the queue.
// ============================================================================
module ccd_tape_line_tracker
  import ccdt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  ccdt_pix_if.sink               pix,
  ccdt_res_if.source             res
);

  ccdt_cfg_t  cfg;
  logic       q_push;
  frame_sum_t q_push_data;
  logic       q_full;
  logic       q_pop;
  frame_sum_t q_head;
  logic       q_empty;

  // configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dark_threshold   <= RST_DARK_THRESHOLD;
      cfg.width_min        <= RST_WIDTH_MIN;
      cfg.width_max        <= RST_WIDTH_MAX;
      cfg.center_reference <= RST_CENTER_REFERENCE;
      cfg.hold_frames      <= RST_HOLD_FRAMES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DARK_THRESHOLD:   cfg.dark_threshold   <= cfg_data;
        REG_WIDTH_MIN:        cfg.width_min        <= cfg_data[7:0];
        REG_WIDTH_MAX:        cfg.width_max        <= cfg_data[7:0];
        REG_CENTER_REFERENCE: cfg.center_reference <= cfg_data[6:0];
        REG_HOLD_FRAMES:      cfg.hold_frames      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // front: pixel scan, one summary per frame
  ccdt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pix       (pix),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  // queue between scanner and result unit
  ccdt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // back: hold/smooth/decay and the result register
  ccdt_back u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .head  (q_head),
    .empty (q_empty),
    .pop   (q_pop),
    .res   (res)
  );

endmodule

// ===== tb/sv/tb_ccd_tape_line_tracker.sv =====
// ============================================================================
// tb_ccd_tape_line_tracker - self-checking bench for the CCD tape line tracker
// Streams pixel frames with random dark runs, predicts each frame result
// (edges, center, hold, decay) in a scoreboard and compares every field.
// ============================================================================
module tb_ccd_tape_line_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import ccdt_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int SETTLE_CYCLES = 12;       // result settling time, plus margin
  localparam int TAIL_CYCLES   = 24;
  localparam int WATCHDOG_NS   = 2_000_000;
  localparam int MAX_FRAME     = 160;

  // sensor geometry and Q0.16 smoothing weights (0.65/0.35, 0.98/0.02)
  localparam int SENSOR_PIXELS = 128;
  localparam longint unsigned FOUND_KEEP = 64'd42598;
  localparam longint unsigned FOUND_TAKE = 64'd22938;
  localparam longint unsigned DECAY_KEEP = 64'd64225;
  localparam longint unsigned DECAY_PULL = 64'd1311;

  // one frame result, field for field as it leaves the block
  typedef struct packed {
    logic       line_ok;
    logic [6:0] center;
    logic [7:0] width;
    logic [6:0] left_idx;
    logic [6:0] right_idx;
    logic [7:0] err;
    logic [7:0] lost;
  } line_result_t;

  // --------------------------------------------------------------------------
  // Frame scoreboard: tracks the scanner and the center filter, queues the
  // result expected at every frame end and checks what comes out.
  // --------------------------------------------------------------------------
  class line_scoreboard;
    logic [11:0] thresh;
    logic [7:0]  min_w;
    logic [7:0]  max_w;
    logic [6:0]  ref_pos;
    logic [7:0]  hold_lim;

    logic [6:0]  pix_idx;
    logic [1:0]  dark_pair;      // bit 0 is the newest pixel
    bit          run_open;
    logic [6:0]  run_left;
    bit          strip_hit;
    logic [6:0]  hit_left;
    logic [6:0]  hit_right;
    logic [7:0]  miss_run;
    logic [22:0] center_q16;
    logic [6:0]  last_center;

    line_result_t expected_q[$];
    int errors;
    int checked;
    int pixels;
    int n_found;
    int n_held;
    int n_decay;

    function new();
      thresh      = 12'd2048;
      min_w       = 8'd3;
      max_w       = 8'd30;
      ref_pos     = 7'd64;
      hold_lim    = 8'd3;
      miss_run    = 8'd0;
      center_q16  = 23'(64 << 16);
      last_center = 7'd64;
      clear_scan();
    endfunction

    function void clear_scan();
      pix_idx     = 7'd0;
      dark_pair   = 2'b00;
      run_open    = 1'b0;
      run_left    = 7'd0;
      strip_hit   = 1'b0;
      hit_left    = 7'd0;
      hit_right   = 7'd0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_reg(reg_index_t idx, logic [11:0] val);
      case (idx)
        REG_DARK_THRESHOLD:   thresh   = val;
        REG_WIDTH_MIN:        min_w    = val[7:0];
        REG_WIDTH_MAX:        max_w    = val[7:0];
        REG_CENTER_REFERENCE: ref_pos  = val[6:0];
        REG_HOLD_FRAMES:      hold_lim = val[7:0];
        default: ;
      endcase
    endfunction

    // edge test at one scan position
    function void probe(int pos, bit d_prev, bit d_here, bit d_next);
      int w;
      if (!run_open && d_here && !d_prev) begin
        run_open = 1'b1;
        run_left = 7'(pos);
      end
      if (run_open && d_here && !d_next) begin
        w = pos - int'(run_left) + 1;
        if (w >= int'(min_w) && w <= int'(max_w)) begin
          strip_hit = 1'b1;
          hit_left  = run_left;
          hit_right = 7'(pos);
        end
        run_open = 1'b0;
      end
    endfunction

    function void note_pixel(logic [11:0] value, logic last);
      bit dark;
      line_result_t r;
      longint unsigned acc;
      logic [6:0] ctr;
      dark = (value < thresh);
      pixels++;
      // position pix_idx-1 is tested once its right neighbour is here
      if (!strip_hit && pix_idx >= 3 && int'(pix_idx) <= SENSOR_PIXELS - 2)
        probe(int'(pix_idx) - 1, dark_pair[1], dark_pair[0], dark);
      dark_pair = {dark_pair[0], dark};
      if (pix_idx < 7'd127) pix_idx++;
      if (!last) return;

      r = '0;
      if (strip_hit) begin
        ctr         = 7'((int'(hit_left) + int'(hit_right)) >> 1);
        r.width     = 8'(int'(hit_right) - int'(hit_left) + 1);
        r.left_idx  = hit_left;
        r.right_idx = hit_right;
        miss_run    = 8'd0;
        acc = FOUND_KEEP * longint'(center_q16) + FOUND_TAKE * (longint'(ctr) << 16);
        center_q16  = 23'(acc >> 16);
        r.line_ok   = 1'b1;
        n_found++;
      end else begin
        if (miss_run != 8'd255) miss_run++;
        if (miss_run <= hold_lim) begin
          ctr = last_center;
          r.line_ok = 1'b1;
          n_held++;
        end else begin
          acc = DECAY_KEEP * longint'(center_q16) + DECAY_PULL * (longint'(ref_pos) << 16);
          center_q16 = 23'(acc >> 16);
          ctr = center_q16[22:16];
          r.line_ok = 1'b0;
          n_decay++;
        end
      end
      last_center = ctr;
      r.center = ctr;
      r.err    = 8'(int'(ctr) - int'(ref_pos));
      r.lost   = miss_run;
      expected_q.push_back(r);
      clear_scan();
    endfunction

    task report(string what, int got, int want);
      if (errors < 40)
        $display("[%0t] frame %0d %s: got %0d, expected %0d", $time, checked, what,
                 got, want);
      errors++;
    endtask

    task check_result(line_result_t got);
      line_result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report("result with no frame outstanding", 0, 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.line_ok !== want.line_ok)
        report("track_valid", got.line_ok, want.line_ok);
      if (got.center !== want.center) report("track_center", got.center, want.center);
      if (got.width !== want.width) report("strip_width", got.width, want.width);
      if (got.left_idx !== want.left_idx)
        report("left_edge", got.left_idx, want.left_idx);
      if (got.right_idx !== want.right_idx)
        report("right_edge", got.right_idx, want.right_idx);
      if (got.err !== want.err)
        report("position_error", $signed(got.err), $signed(want.err));
      if (got.lost !== want.lost) report("lost_count", got.lost, want.lost);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  always #(CLK_PERIOD / 2) clk = ~clk;

  ccdt_pix_if pix_ch();
  ccdt_res_if res_ch();

  ccd_tape_line_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix_ch.sink),
    .res       (res_ch.source)
  );

  line_scoreboard sb = new();

  bit src_calm  = 1'b0;   // sender runs with no gaps while set
  bit sink_calm = 1'b0;   // receiver never stalls while set
  int sink_wait = 0;
  logic sink_rdy = 1'b0;
  int cfg_sets  = 0;

  assign res_ch.ready = sink_rdy;

  // gap before a transfer: half the draws give none, the rest a random gap, possibly none
  function automatic int draw_wait();
    if ($urandom_range(1) == 0) return 0;
    return $urandom_range(13, 0);
  endfunction

  // --------------------------------------------------------------------------
  // Result receiver: after every transfer it draws how long ready stays low.
  // Ready may also be low before a result shows up, so stalls hit every
  // phase of the result unit.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : sink_side
    int w;
    if (rst) begin
      sink_rdy  <= 1'b0;
      sink_wait <= 2;
    end else if (sink_rdy && res_ch.valid) begin
      if ($urandom_range(15) == 0) sink_calm = !sink_calm;
      w = sink_calm ? 0 : draw_wait();
      if (w != 0) begin
        sink_rdy  <= 1'b0;
        sink_wait <= w - 1;
      end
    end else if (!sink_rdy) begin
      if (sink_wait == 0) sink_rdy <= 1'b1;
      else sink_wait <= sink_wait - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: values read here are the ones present at the clock edge, since
  // every driver updates through nonblocking assignments.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    line_result_t got;
    if (!rst) begin
      if (pix_ch.valid && pix_ch.ready)
        sb.note_pixel(pix_ch.pixel_value, pix_ch.frame_end);
      if (res_ch.valid && res_ch.ready) begin
        got.line_ok    = res_ch.track_valid;
        got.center     = res_ch.track_center;
        got.width      = res_ch.strip_width;
        got.left_idx   = res_ch.left_edge;
        got.right_idx  = res_ch.right_edge;
        got.err        = res_ch.position_error;
        got.lost       = res_ch.lost_count;
        sb.check_result(got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pixel driver. Valid stays high across back-to-back transfers; it only
  // drops for a drawn gap or a drain.
  // --------------------------------------------------------------------------
  task automatic send_pixel(input logic [11:0] value, input logic last);
    int gap;
    gap = src_calm ? 0 : draw_wait();
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel_value <= value;
    pix_ch.frame_end   <= last;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
  endtask

  // sender pauses until every outstanding frame result has been checked
  task automatic hold_until_drained();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // a pixel value on the requested side of the threshold, hugging it at
  // times, with a little fully random noise
  function automatic logic [11:0] pixel_for(input bit dark);
    int th;
    int r;
    th = int'(sb.thresh);
    r  = $urandom_range(99);
    if (r < 4) return 12'($urandom_range(4095, 0));
    if (dark && th > 0) begin
      if (r < 12) return 12'(th - 1);
      return 12'($urandom_range(th - 1, 0));
    end
    if (r < 12) return 12'(th);
    return 12'($urandom_range(4095, th));
  endfunction

  // one frame of len pixels with zero to three dark runs of random width;
  // narrow or wide runs exercise the width rejection and rescan
  task automatic send_frame(input int len);
    bit dark_mask [MAX_FRAME];
    int runs;
    int start;
    int span;
    int r;
    for (int k = 0; k < MAX_FRAME; k++) dark_mask[k] = 1'b0;
    r    = $urandom_range(99);
    runs = (r < 20) ? 0 : (r < 65) ? 1 : (r < 88) ? 2 : 3;
    repeat (runs) begin
      start = $urandom_range(len - 1, 0);
      r     = $urandom_range(99);
      if (r < 70) span = $urandom_range(12, 1);
      else if (r < 90) span = $urandom_range(40, 13);
      else span = $urandom_range(128, 41);
      for (int k = start; k < start + span && k < len; k++) dark_mask[k] = 1'b1;
    end
    for (int k = 0; k < len; k++) send_pixel(pixel_for(dark_mask[k]), k == len - 1);
  endtask

  // random frames until about budget pixels went out; mostly short frames,
  // some tiny ones, a few that run past the end of the sensor
  task automatic random_frames(input int budget);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(9) == 0) src_calm = !src_calm;
      r = $urandom_range(99);
      if (r < 60) len = $urandom_range(32, 6);
      else if (r < 72) len = $urandom_range(100, 33);
      else if (r < 84) len = $urandom_range(5, 1);
      else if (r < 90) len = $urandom_range(140, 126);
      else len = $urandom_range(16, 4);
      send_frame(len);
      sent += len;
      if ($urandom_range(14) == 0) hold_until_drained();
    end
  endtask

  // register write; we stays high across the whole burst
  task automatic put_reg(input reg_index_t idx, input logic [11:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // full register set, written only once the block has gone quiet
  task automatic write_cfg(input logic [11:0] th, input logic [7:0] wmin,
                           input logic [7:0] wmax, input logic [6:0] ctr_ref,
                           input logic [7:0] hold);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    put_reg(REG_DARK_THRESHOLD, th);
    put_reg(REG_WIDTH_MIN, 12'(wmin));
    put_reg(REG_WIDTH_MAX, 12'(wmax));
    put_reg(REG_CENTER_REFERENCE, 12'(ctr_ref));
    put_reg(REG_HOLD_FRAMES, 12'(hold));
    cfg_we <= 1'b0;
    cfg_sets++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    // hand-picked frames under the reset settings:
    //   clean width-3 tape at 2..4, pixel extremes and both threshold sides;
    //   a three-pixel frame that is too short to scan;
    //   a one-pixel frame;
    //   a width-2 run that is rejected, giving the last held frame;
    //   one more lost frame, which starts the decay toward the reference
    logic [11:0] dir_pix [22] = '{
      12'd4095, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd2048,
      12'd0, 12'd0, 12'd0,
      12'd2047,
      12'd4095, 12'd4095, 12'd2047, 12'd2047, 12'd4095, 12'd4095, 12'd4095,
      12'd4095, 12'd4095,
      12'd0};
    bit dir_end [22] = '{
      0, 0, 0, 0, 0, 0, 0, 1,
      0, 0, 1,
      1,
      0, 0, 0, 0, 0, 0, 0, 0, 1,
      1};

    pix_ch.valid       <= 1'b0;
    pix_ch.pixel_value <= '0;
    pix_ch.frame_end   <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_DARK_THRESHOLD;
    cfg_data           <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < 22; k++) send_pixel(dir_pix[k], dir_end[k]);
    random_frames(200);

    // everything dark but 4095, any width, reference at the left end,
    // no hold: lost frames decay at once
    write_cfg(12'd4095, 8'd1, 8'd128, 7'd0, 8'd0);
    random_frames(100);

    // nothing is dark, widths at the top, reference at the right end,
    // the held center stays for ever
    write_cfg(12'd0, 8'd128, 8'd128, 7'd127, 8'd255);
    random_frames(80);

    // crossed width limits reject every run; then a long string of tiny
    // frames drives the lost count into saturation while still held
    write_cfg(12'($urandom_range(3500, 500)), 8'd40, 8'd10,
              7'($urandom_range(127, 0)), 8'd255);
    random_frames(60);
    repeat (260) send_frame(($urandom_range(3) == 0) ? 2 : 1);

    // ordinary random settings
    repeat (4) begin
      write_cfg(12'($urandom_range(3500, 500)), 8'($urandom_range(8, 1)),
                8'($urandom_range(128, 8)), 7'($urandom_range(127, 0)),
                8'($urandom_range(6, 0)));
      random_frames(80);
    end

    // drain, then let the block run quiet for a while to catch strays
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d pixel transfers and %0d frame results over %0d register sets",
             sb.pixels, sb.checked, cfg_sets + 1);
    $display("frame outcomes: %0d found, %0d held, %0d decaying; %0d mismatches",
             sb.n_found, sb.n_held, sb.n_decay, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("timeout with %0d frame results outstanding", sb.pending());
    $display("TB_ERROR");
    $finish;
  end

endmodule
